// ----- sv/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int KEY_W      = 32;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CAPACITY_D = 64;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_KEY = 2'd1,
    OP_DEL_MAX = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del_le;
    logic del_all;
    key_t key;
  } cell_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// one slot of the sorted chain: key, valid flag and compare flags
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::key_t     prev_key,
  input  logic              prev_valid,
  input  logic              prev_ins,
  input  spq_pkg::key_t     next_key,
  input  logic              next_valid,
  output spq_pkg::key_t     key_q,
  output logic              valid_q,
  output logic              ins_here,
  output logic              eq_q
);

  logic le;

  assign ins_here = !valid_q || le;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      le      <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        le   <= valid_q && (key_q <= cmd.key);
        eq_q <= valid_q && (key_q == cmd.key);
      end
      if (cmd.ins) begin
        valid_q <= valid_q | prev_valid;
      end else if (cmd.del_all || (cmd.del_le && le)) begin
        valid_q <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (ins_here) begin
        key_q <= prev_ins ? prev_key : cmd.key;
      end
    end else if (cmd.del_all || (cmd.del_le && le)) begin
      key_q <= next_key;
    end
  end

endmodule

// ----- sv/sorted_priority_queue_top.sv -----
// top level of the sorted priority queue: cell chain, sequencer and result register
// Keys are held in descending order in a chain of CAPACITY cells, each cell
// talking only to its two neighbours. An item's result is registered after a
// compare step in which every cell compares its key with the item's key, and
// then a shift step in which the chain shifts (right to insert, left to
// delete). A new item is taken only in the idle state, which is entered when
// the previous result is registered, so the queue does not take a new item
// before it is through with the last one; a result that is not taken holds
// the next item in its shift step. Among equal keys the newest is held nearest
// the head. count reports the number of stored keys in seven bits.
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_D
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [spq_pkg::OPCODE_W-1:0]   opcode,
  input  logic signed [spq_pkg::KEY_W-1:0] key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output logic signed [spq_pkg::KEY_W-1:0] key_out,
  output logic [spq_pkg::COUNT_W-1:0]    count,
  output logic                           is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                     state;
  spq_pkg::opcode_t           op;
  spq_pkg::key_t              op_key;
  logic [CNT_W-1:0]           cnt;
  logic [CNT_W-1:0]           cnt_next;
  spq_pkg::cell_cmd_t         cmd;
  spq_pkg::status_t           res_status;
  spq_pkg::key_t              res_key;

  spq_pkg::key_t              cell_key   [CAPACITY];
  logic [CAPACITY-1:0]        cell_valid;
  logic [CAPACITY-1:0]        cell_ins;
  logic [CAPACITY-1:0]        cell_eq;

  logic found;
  logic full;
  logic empty;
  logic out_free;

  assign found    = |cell_eq;
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign empty    = (cnt == '0);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // command for the compare and shift cycles, and result for the shift cycle
  always_comb begin
    cmd         = '0;
    cmd.key     = op_key;
    cnt_next    = cnt;
    res_status  = spq_pkg::ST_OK;
    res_key     = op_key;
    if (state == S_CMP) begin
      cmd.cmp = 1'b1;
    end
    case (op)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          res_status = spq_pkg::ST_FULL;
        end else begin
          cmd.ins  = (state == S_APPLY) && out_free;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      spq_pkg::OP_DEL_KEY: begin
        if (found) begin
          cmd.del_le = (state == S_APPLY) && out_free;
          cnt_next   = cnt - CNT_W'(1);
        end else begin
          res_status = spq_pkg::ST_NOTFOUND;
        end
      end
      spq_pkg::OP_DEL_MAX: begin
        if (empty) begin
          res_status = spq_pkg::ST_EMPTY;
          res_key    = '0;
        end else begin
          cmd.del_all = (state == S_APPLY) && out_free;
          cnt_next    = cnt - CNT_W'(1);
          res_key     = cell_key[0];
        end
      end
      default: begin
        res_key = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= spq_pkg::opcode_t'(opcode);
            op_key <= key;
            state  <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            cnt       <= cnt_next;
            out_valid <= 1'b1;
            status    <= res_status;
            key_out   <= res_key;
            count     <= spq_pkg::COUNT_W'(cnt_next);
            is_empty  <= (cnt_next == '0);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::key_t pk;
    logic          pv;
    logic          pi;
    spq_pkg::key_t nk;
    logic          nv;

    if (i == 0) begin : g_head
      assign pk = '0;
      assign pv = 1'b1;
      assign pi = 1'b0;
    end else begin : g_mid
      assign pk = cell_key[i-1];
      assign pv = cell_valid[i-1];
      assign pi = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nk = '0;
      assign nv = 1'b0;
    end else begin : g_body
      assign nk = cell_key[i+1];
      assign nv = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_key   (pk),
      .prev_valid (pv),
      .prev_ins   (pi),
      .next_key   (nk),
      .next_valid (nv),
      .key_q      (cell_key[i]),
      .valid_q    (cell_valid[i]),
      .ins_here   (cell_ins[i]),
      .eq_q       (cell_eq[i])
    );
  end

endmodule
